### hw/rtl/assert_macros.svh
// Assertion helpers for the RTL tree.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must hold on every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`endif

### hw/rtl/twok_pkg.sv
package twok_pkg;

  localparam int unsigned ANGLE_BITS     = 16;
  localparam int unsigned DUTY_FRAC_BITS = 14;
  localparam int unsigned TRIG_STAGES    = 16;

  localparam int unsigned WORK_FRAC     = 29;
  localparam int unsigned CORDIC_GAIN   = 39797;
  localparam longint     HALF_SQRT3    = 64'sd929887697;

  localparam int unsigned XW = 36;
  localparam int unsigned ZW = 33;
  localparam int unsigned PW = XW + 31;
  localparam int unsigned DW = 40;
  localparam int unsigned RW = DW + 1;
  localparam int unsigned QW = DUTY_FRAC_BITS + 2;

  localparam int unsigned AW = 3;
  localparam logic [AW-1:0] ADDR_REVERSE_ALL = 3'd0;

  typedef struct packed {
    logic [15:0]        heading_angle;
    logic signed [15:0] linear_speed;
    logic signed [15:0] rotation_rate;
  } cmd_t;

  typedef struct packed {
    logic signed [15:0] front_duty;
    logic signed [15:0] left_duty;
    logic signed [15:0] right_duty;
    logic               was_scaled;
  } duty_t;

  function automatic logic signed [ZW-1:0] atan_turn(input int unsigned idx);
    logic [31:0] v;
    case (idx)
      0:  v = 32'd536870912;
      1:  v = 32'd316933406;
      2:  v = 32'd167458907;
      3:  v = 32'd85004756;
      4:  v = 32'd42667331;
      5:  v = 32'd21354465;
      6:  v = 32'd10680862;
      7:  v = 32'd5340245;
      8:  v = 32'd2670163;
      9:  v = 32'd1335087;
      10: v = 32'd667544;
      11: v = 32'd333772;
      12: v = 32'd166886;
      13: v = 32'd83443;
      14: v = 32'd41722;
      15: v = 32'd20861;
      16: v = 32'd10430;
      17: v = 32'd5215;
      18: v = 32'd2608;
      19: v = 32'd1304;
      20: v = 32'd652;
      21: v = 32'd326;
      22: v = 32'd163;
      23: v = 32'd81;
      default: v = 32'd0;
    endcase
    return $signed({{(ZW-32){1'b0}}, v});
  endfunction

endpackage

### hw/rtl/three_wheel_omni_kinematics_core.sv
// Channel   Dir  Handshake                  Payload
// cmd       in   cmd_valid_i / cmd_ready_o  twok_pkg::cmd_t
// duty      out  duty_valid_o / duty_ready_i twok_pkg::duty_t
// apb       in   psel/penable/pwrite/pready reverse_all at byte address 0
//
// One command per cycle while the output register is empty or taken; TRIG_STAGES +
// DUTY_FRAC_BITS + 7 register stages (37 at the defaults), set by the CORDIC stages
// and the bit-per-stage divider.
// All stages advance together whenever the output register is empty or taken.
// Reset clears the valid bits and reverse_all; data registers carry no reset.
`include "assert_macros.svh"

module three_wheel_omni_kinematics_core (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cmd_valid_i,
  output logic                     cmd_ready_o,
  input  twok_pkg::cmd_t           cmd_i,
  output logic                     duty_valid_o,
  input  logic                     duty_ready_i,
  output twok_pkg::duty_t          duty_o,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [twok_pkg::AW-1:0]  paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  localparam int unsigned T   = twok_pkg::TRIG_STAGES;
  localparam int unsigned F   = twok_pkg::DUTY_FRAC_BITS;
  localparam int unsigned XW  = twok_pkg::XW;
  localparam int unsigned ZW  = twok_pkg::ZW;
  localparam int unsigned PW  = twok_pkg::PW;
  localparam int unsigned DW  = twok_pkg::DW;
  localparam int unsigned RW  = twok_pkg::RW;
  localparam int unsigned QW  = twok_pkg::QW;
  localparam int unsigned WF  = twok_pkg::WORK_FRAC;
  localparam int unsigned NST = T + F + 7;

  localparam logic [31:0] AMASK = 32'((64'd1 << twok_pkg::ANGLE_BITS) - 64'd1);
  localparam logic signed [XW-1:0] GAIN = XW'(twok_pkg::CORDIC_GAIN);
  localparam logic signed [ZW-1:0] QUARTER = ZW'(64'sd1 << 30);
  localparam logic signed [ZW-1:0] HALF_TURN = ZW'(64'sd1 << 31);
  localparam logic signed [PW-1:0] K_SQRT = PW'(twok_pkg::HALF_SQRT3);
  localparam logic signed [PW-1:0] S_RND = PW'(64'sd1 << 28);
  localparam logic [DW-1:0] ONE_WORK = DW'(64'd1 << WF);
  localparam logic [DW-1:0] U_RND = DW'(64'd1 << (WF - F - 1));
  localparam logic [QW-1:0] ONE_Q = QW'(64'd1 << F);
  localparam logic [QW-1:0] Q_MAX = QW'(64'd32767);

  typedef struct packed {
    logic [2:0][RW-1:0] r;
    logic [2:0][QW-1:0] q;
    logic [2:0][QW-1:0] uq;
    logic [2:0]         neg;
    logic [DW-1:0]      m;
    logic               scaled;
  } div_t;

  logic reverse_q;
  logic [NST-1:0] v_q;
  logic adv;

  assign pready = 1'b1;
  assign prdata = (paddr == twok_pkg::ADDR_REVERSE_ALL) ? {31'd0, reverse_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reverse_q <= 1'b0;
    end else if (psel && penable && pwrite && pready &&
                 paddr == twok_pkg::ADDR_REVERSE_ALL) begin
      reverse_q <= pwdata[0];
    end
  end

  assign adv = !v_q[NST-1] || duty_ready_i;
  assign cmd_ready_o = adv;
  assign duty_valid_o = v_q[NST-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[NST-2:0], cmd_valid_i};
    end
  end

  // fold the angle into the right half-plane and scale the speed
  logic signed [XW-1:0] cx_q [T+1];
  logic signed [XW-1:0] cy_q [T+1];
  logic signed [ZW-1:0] cz_q [T+1];
  logic signed [15:0]   cw_q [T+1];
  logic [31:0]          a32;
  logic signed [ZW-1:0] z0;
  logic signed [XW-1:0] x0;

  always_comb begin
    a32 = ({16'd0, cmd_i.heading_angle} & AMASK) << (32 - twok_pkg::ANGLE_BITS);
    z0  = ZW'($signed(a32));
    x0  = XW'(cmd_i.linear_speed) * GAIN;
    if (z0 >= QUARTER) begin
      x0 = -x0;
      z0 = z0 - HALF_TURN;
    end else if (z0 < -QUARTER) begin
      x0 = -x0;
      z0 = z0 + HALF_TURN;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cx_q[0] <= x0;
      cy_q[0] <= '0;
      cz_q[0] <= z0;
      cw_q[0] <= cmd_i.rotation_rate;
    end
  end

  for (genvar i = 0; i < T; i++) begin : g_cordic
    logic signed [XW-1:0] dx, dy;
    assign dx = cy_q[i] >>> i;
    assign dy = cx_q[i] >>> i;
    always_ff @(posedge clk_i) begin
      if (adv) begin
        cw_q[i+1] <= cw_q[i];
        if (cz_q[i] >= 0) begin
          cx_q[i+1] <= cx_q[i] - dx;
          cy_q[i+1] <= cy_q[i] + dy;
          cz_q[i+1] <= cz_q[i] - twok_pkg::atan_turn(i);
        end else begin
          cx_q[i+1] <= cx_q[i] + dx;
          cy_q[i+1] <= cy_q[i] - dy;
          cz_q[i+1] <= cz_q[i] + twok_pkg::atan_turn(i);
        end
      end
    end
  end

  // sqrt3/2 * vy
  logic signed [PW-1:0] mp_q;
  logic signed [XW-1:0] mx_q;
  logic signed [15:0]   mw_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mp_q <= PW'(cy_q[T]) * K_SQRT;
      mx_q <= cx_q[T];
      mw_q <= cw_q[T];
    end
  end

  // wheel mixing
  logic signed [PW-1:0] sp;
  logic signed [DW-1:0] s, xw, wq;
  logic signed [DW-1:0] dd_d [3];
  logic signed [DW-1:0] dd_q [3];

  always_comb begin
    sp = (mp_q + S_RND) >>> 29;
    s  = DW'(sp);
    xw = DW'(mx_q);
    wq = DW'(mw_q) <<< 17;
    dd_d[0] = wq - (xw <<< 1);
    dd_d[1] = xw - s + wq;
    dd_d[2] = xw + s + wq;
    if (reverse_q) begin
      for (int k = 0; k < 3; k++) dd_d[k] = -dd_d[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dd_q <= dd_d;
    end
  end

  // magnitudes
  logic [DW-1:0] ab_q [3];
  logic [2:0]    ng_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        ab_q[k] <= dd_q[k][DW-1] ? DW'(-dd_q[k]) : DW'(dd_q[k]);
        ng_q[k] <= dd_q[k][DW-1];
      end
    end
  end

  // largest magnitude, unscaled rounding
  div_t dv_q [F+2];
  div_t mx_d;
  logic [DW-1:0] m01, ush;

  always_comb begin
    mx_d = '0;
    m01 = (ab_q[1] > ab_q[0]) ? ab_q[1] : ab_q[0];
    mx_d.m = (ab_q[2] > m01) ? ab_q[2] : m01;
    mx_d.scaled = mx_d.m > ONE_WORK;
    mx_d.neg = ng_q;
    ush = '0;
    for (int k = 0; k < 3; k++) begin
      mx_d.r[k] = RW'(ab_q[k]);
      ush = (ab_q[k] + U_RND) >> (WF - F);
      mx_d.uq[k] = (ush > DW'(ONE_Q)) ? ONE_Q : QW'(ush);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dv_q[0] <= mx_d;
    end
  end

  // restoring division, one quotient bit per stage
  for (genvar j = 0; j <= F; j++) begin : g_div
    div_t nx;
    always_comb begin
      logic [RW-1:0] rin;
      logic          bit_q;
      nx = dv_q[j];
      for (int k = 0; k < 3; k++) begin
        rin = (j == 0) ? dv_q[j].r[k] : (dv_q[j].r[k] << 1);
        bit_q = rin >= RW'(dv_q[j].m);
        nx.r[k] = bit_q ? rin - RW'(dv_q[j].m) : rin;
        nx.q[k] = {dv_q[j].q[k][QW-2:0], bit_q};
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        dv_q[j+1] <= nx;
      end
    end
  end

  // round, saturate, apply sign
  twok_pkg::duty_t out_d, out_q;
  logic [QW-1:0] qf [3];
  logic signed [15:0] res [3];
  div_t fin;

  always_comb begin
    fin = dv_q[F+1];
    for (int k = 0; k < 3; k++) begin
      qf[k] = fin.q[k];
      if ((fin.r[k] + RW'(fin.m >> 1)) >= RW'(fin.m)) qf[k] = qf[k] + QW'(1);
      if (!fin.scaled) qf[k] = fin.uq[k];
      if (qf[k] > ONE_Q) qf[k] = ONE_Q;
      if (qf[k] > Q_MAX) qf[k] = Q_MAX;
      res[k] = fin.neg[k] ? -$signed(16'(qf[k])) : $signed(16'(qf[k]));
    end
    out_d.front_duty = res[0];
    out_d.left_duty  = res[1];
    out_d.right_duty = res[2];
    out_d.was_scaled = fin.scaled;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

  assign duty_o = out_q;

  `ASSERT_IMPL(a_enter, clk_i, rst_ni, cmd_valid_i && cmd_ready_o |=> v_q[0],
               "accepted command missing from first stage")
  `ASSERT_ALWAYS(a_ready, clk_i, rst_ni, cmd_ready_o == (!duty_valid_o || duty_ready_i),
                 "input ready does not follow output stall")
  `ASSERT_IMPL(a_range, clk_i, rst_ni,
               duty_valid_o |-> (duty_o.front_duty <= 16'sd16384 &&
                                 duty_o.front_duty >= -16'sd16384),
               "front duty out of range")
  `ASSERT_IMPL(a_scaled_peak, clk_i, rst_ni,
               duty_valid_o && duty_o.was_scaled |->
                 (duty_o.front_duty == 16'sd16384 || duty_o.front_duty == -16'sd16384 ||
                  duty_o.left_duty == 16'sd16384 || duty_o.left_duty == -16'sd16384 ||
                  duty_o.right_duty == 16'sd16384 || duty_o.right_duty == -16'sd16384),
               "scaled result without a full-scale duty")

endmodule
